/* design/abp_pkg.sv */
// Shared constants, types and a helper function for the alpha bitmask packer.
`default_nettype none

package abp_pkg;

   localparam int ABP_MAX_DIM = 4096;

   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = 5;
   localparam int INDEX_W     = 19;
   localparam int DIST_W      = 35;
   localparam int ALPHA_W     = 8;
   localparam int DIM_CFG_W   = 13;
   localparam int DEC_W       = 4;
   localparam int PHASE_W     = 3;
   localparam int CENTER_W    = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int DEC_MAX     = 8;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_DECIMATION   = 3'd2,
      CSR_CENTER_X     = 3'd3,
      CSR_CENTER_Y     = 3'd4
   } abp_csr_type;

   // per-item control travelling down the pipeline
   typedef struct packed {
      logic               opaque;
      logic               emit;
      logic               last;
      logic               clear;
      logic [BIT_W-1:0]   bit_pos;
      logic [INDEX_W-1:0] word_index;
   } abp_ctl_type;

   // signed width of a centre offset: 16*cell minus a Q.4 centre
   function automatic int abp_dx_width(input int max_dim);
      int cnt_w;
      int span_w;
      cnt_w  = $clog2(max_dim);
      span_w = cnt_w + 5;
      if (span_w < CENTER_W) begin
         span_w = CENTER_W;
      end
      return span_w + 1;
   endfunction

endpackage

`default_nettype wire

/* design/alpha_bitmask_packer_unit.sv */
// Top level of the alpha bitmask packer: register file, limit clamps and the three stages.
//
//   channel | direction | transfer when         | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   req     | in        | req_valid & req_ready | req_alpha
//   rsp     | out       | rsp_valid & rsp_ready | rsp_mask_word, rsp_word_index,
//           |           |                       | rsp_mask_done, rsp_max_dist_sq
//   csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// One pixel is taken per cycle unless a held result stalls the input; a word appears on rsp
// once the pixel that completes it has passed the scan, square and pack registers in turn.
// The scan counters that set this pace advance only on a pixel that is taken.
// Reset is synchronous: counters, accumulators and valid flags clear, registers take
// their defaults (32 x 32, decimation 1, centre at origin). No clearing pass is needed.
// A held result stalls only pixels that would emit another word; pixels that emit nothing
// keep flowing while rsp_ready is low, so up to two pixels sit behind a waiting result.
`default_nettype none

module alpha_bitmask_packer_unit
   import abp_pkg::*;
#(
   parameter int MAX_DIM = ABP_MAX_DIM
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_write_en,
   input  wire  [CSR_INDEX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]    csr_wdata,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [ALPHA_W-1:0]       req_alpha,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [WORD_BITS-1:0]     rsp_mask_word,
   output logic [INDEX_W-1:0]       rsp_word_index,
   output logic                     rsp_mask_done,
   output logic [DIST_W-1:0]        rsp_max_dist_sq
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
   localparam int DX_W  = abp_dx_width(MAX_DIM);
   localparam int SQ_W  = 2 * DX_W;

   // configuration registers
   logic [DIM_CFG_W-1:0]       width_ff, width_in;
   logic [DIM_CFG_W-1:0]       height_ff, height_in;
   logic [DEC_W-1:0]           dec_ff, dec_in;
   logic signed [CENTER_W-1:0] center_x_ff, center_x_in;
   logic signed [CENTER_W-1:0] center_y_ff, center_y_in;

   // clamped working values
   logic [CMP_W-1:0]           width_ext, height_ext, width_lim, height_lim;
   logic [DIM_W-1:0]           width_eff, height_eff;
   logic [DEC_W-1:0]           dec_eff;

   // stage links
   logic                       s1_valid, s1_ready;
   abp_ctl_type                s1_ctl;
   logic signed [DX_W-1:0]     s1_dx, s1_dy;
   logic                       s2_valid, s2_ready;
   abp_ctl_type                s2_ctl;
   logic [SQ_W-1:0]            s2_sq_x, s2_sq_y;

   // register writes: an index beyond the list is ignored
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      dec_in      = dec_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_write_en) begin
         case (abp_csr_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[DIM_CFG_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[DIM_CFG_W-1:0];
            end
            CSR_DECIMATION: begin
               dec_in = csr_wdata[DEC_W-1:0];
            end
            CSR_CENTER_X: begin
               center_x_in = $signed(csr_wdata[CENTER_W-1:0]);
            end
            CSR_CENTER_Y: begin
               center_y_in = $signed(csr_wdata[CENTER_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_CFG_W'(32);
         height_ff   <= DIM_CFG_W'(32);
         dec_ff      <= DEC_W'(1);
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         dec_ff      <= dec_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   // zero dimensions act as one, oversize ones saturate at the largest image;
   // decimation zero acts as one and anything above eight saturates
   always_comb begin
      width_ext  = CMP_W'(width_ff);
      height_ext = CMP_W'(height_ff);
      if (width_ext == '0) begin
         width_lim = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_DIM)) begin
         width_lim = CMP_W'(MAX_DIM);
      end else begin
         width_lim = width_ext;
      end
      if (height_ext == '0) begin
         height_lim = CMP_W'(1);
      end else if (height_ext > CMP_W'(MAX_DIM)) begin
         height_lim = CMP_W'(MAX_DIM);
      end else begin
         height_lim = height_ext;
      end
      width_eff  = width_lim[DIM_W-1:0];
      height_eff = height_lim[DIM_W-1:0];
      if (dec_ff == '0) begin
         dec_eff = DEC_W'(1);
      end else if (dec_ff > DEC_W'(DEC_MAX)) begin
         dec_eff = DEC_W'(DEC_MAX);
      end else begin
         dec_eff = dec_ff;
      end
   end

   // walk the source raster, pick kept cells, work out word slots and offsets
   abp_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg_width    (width_eff),
      .cfg_height   (height_eff),
      .cfg_dec      (dec_eff),
      .cfg_center_x (center_x_ff),
      .cfg_center_y (center_y_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_alpha     (req_alpha),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_ctl      (s1_ctl),
      .out_dx       (s1_dx),
      .out_dy       (s1_dy)
   );

   // square the offsets
   abp_square #(
      .MAX_DIM (MAX_DIM)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_ctl    (s1_ctl),
      .in_dx     (s1_dx),
      .in_dy     (s1_dy),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_ctl   (s2_ctl),
      .out_sq_x  (s2_sq_x),
      .out_sq_y  (s2_sq_y)
   );

   // fold into the current word and the running maximum, hold the result
   abp_pack #(
      .MAX_DIM (MAX_DIM)
   ) u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_valid),
      .in_ready        (s2_ready),
      .in_ctl          (s2_ctl),
      .in_sq_x         (s2_sq_x),
      .in_sq_y         (s2_sq_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mask_word   (rsp_mask_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_mask_done   (rsp_mask_done),
      .rsp_max_dist_sq (rsp_max_dist_sq)
   );

`ifndef ASSERT_OFF
   // input is refused only when a result is waiting on the output
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a pixel that emits nothing never waits in the square stage
   a_silent_flows: assert property (@(posedge clock) disable iff (reset)
      s2_valid && !s2_ctl.emit |-> s2_ready)
      else $error("non-emitting pixel held in square stage");

   // the final word of a mask is always an emitted word
   a_last_is_emit: assert property (@(posedge clock) disable iff (reset)
      s1_valid && s1_ctl.last |-> s1_ctl.emit)
      else $error("last flag on a pixel that emits no word");

   // distance is zero on every word but the final one
   a_dist_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mask_done |-> rsp_max_dist_sq == '0)
      else $error("distance on a word that is not the final one");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

/* design/abp_scan.sv */
// Scan stage: source and cell counters, mask bounds, word slots and centre offsets.
`default_nettype none

module abp_scan
   import abp_pkg::*;
#(
   parameter int MAX_DIM = ABP_MAX_DIM
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  [$clog2(MAX_DIM+1)-1:0]             cfg_width,
   input  wire  [$clog2(MAX_DIM+1)-1:0]             cfg_height,
   input  wire  [DEC_W-1:0]                         cfg_dec,
   input  wire  signed [CENTER_W-1:0]               cfg_center_x,
   input  wire  signed [CENTER_W-1:0]               cfg_center_y,
   input  wire                                      in_valid,
   output logic                                     in_ready,
   input  wire  [ALPHA_W-1:0]                       in_alpha,
   output logic                                     out_valid,
   input  wire                                      out_ready,
   output abp_ctl_type                              out_ctl,
   output logic signed [abp_dx_width(MAX_DIM)-1:0]  out_dx,
   output logic signed [abp_dx_width(MAX_DIM)-1:0]  out_dy
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int PROD_W = CNT_W + 1 + DEC_W;
   localparam int DX_W   = abp_dx_width(MAX_DIM);

   logic [CNT_W-1:0]   src_col_ff, src_col_in;
   logic [CNT_W-1:0]   src_row_ff, src_row_in;
   logic [CNT_W-1:0]   cell_col_ff, cell_col_in;
   logic [CNT_W-1:0]   cell_row_ff, cell_row_in;
   logic [PHASE_W-1:0] phase_col_ff, phase_col_in;
   logic [PHASE_W-1:0] phase_row_ff, phase_row_in;
   logic [INDEX_W-1:0] word_count_ff, word_count_in;
   logic               valid_ff, valid_in;
   abp_ctl_type        ctl_ff, ctl_in;
   logic signed [DX_W-1:0] dx_ff, dx_in;
   logic signed [DX_W-1:0] dy_ff, dy_in;

   logic               fire;
   logic [CNT_W:0]     col_cell_step, row_cell_step;
   logic [CNT_W:0]     src_col_step, src_row_step;
   logic [PHASE_W:0]   phase_col_step, phase_row_step;
   logic [PROD_W-1:0]  col_prod, row_prod, col_rest, row_rest;
   logic [PROD_W-1:0]  width_ext, height_ext, dec_ext;
   logic               in_col, in_row, last_col, last_row, kept, full_word;
   logic               col_wrap, row_wrap;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      width_ext     = PROD_W'(cfg_width);
      height_ext    = PROD_W'(cfg_height);
      dec_ext       = PROD_W'(cfg_dec);
      col_cell_step = {1'b0, cell_col_ff} + (CNT_W+1)'(1);
      row_cell_step = {1'b0, cell_row_ff} + (CNT_W+1)'(1);
      // cell < floor(dim/dec)  <=>  (cell+1)*dec <= dim
      col_prod      = PROD_W'(col_cell_step) * dec_ext;
      row_prod      = PROD_W'(row_cell_step) * dec_ext;
      in_col        = col_prod <= width_ext;
      in_row        = row_prod <= height_ext;
      col_rest      = width_ext - col_prod;
      row_rest      = height_ext - row_prod;
      last_col      = in_col && (col_rest < dec_ext);
      last_row      = in_row && (row_rest < dec_ext);
      kept          = (phase_col_ff == '0) && (phase_row_ff == '0) && in_col && in_row;
      full_word     = cell_col_ff[BIT_W-1:0] == BIT_W'(WORD_BITS - 1);

      ctl_in.opaque     = kept && (in_alpha != '0);
      ctl_in.emit       = kept && (full_word || last_col);
      ctl_in.last       = kept && last_col && last_row;
      ctl_in.bit_pos    = cell_col_ff[BIT_W-1:0];
      ctl_in.word_index = word_count_ff;

      dx_in = DX_W'($signed({1'b0, cell_col_ff, 4'b0000})) - DX_W'(cfg_center_x);
      dy_in = DX_W'($signed({1'b0, cell_row_ff, 4'b0000})) - DX_W'(cfg_center_y);

      src_col_step   = {1'b0, src_col_ff} + (CNT_W+1)'(1);
      src_row_step   = {1'b0, src_row_ff} + (CNT_W+1)'(1);
      phase_col_step = {1'b0, phase_col_ff} + (PHASE_W+1)'(1);
      phase_row_step = {1'b0, phase_row_ff} + (PHASE_W+1)'(1);
      col_wrap       = src_col_step >= (CNT_W+1)'(cfg_width);
      row_wrap       = src_row_step >= (CNT_W+1)'(cfg_height);
      ctl_in.clear   = col_wrap && row_wrap;

      src_col_in    = src_col_ff;
      src_row_in    = src_row_ff;
      cell_col_in   = cell_col_ff;
      cell_row_in   = cell_row_ff;
      phase_col_in  = phase_col_ff;
      phase_row_in  = phase_row_ff;
      word_count_in = word_count_ff;

      if (fire) begin
         if (ctl_in.emit) begin
            word_count_in = word_count_ff + INDEX_W'(1);
         end
         if (col_wrap) begin
            src_col_in   = '0;
            phase_col_in = '0;
            cell_col_in  = '0;
            if (row_wrap) begin
               src_row_in    = '0;
               phase_row_in  = '0;
               cell_row_in   = '0;
               word_count_in = '0;
            end else begin
               src_row_in = src_row_step[CNT_W-1:0];
               if (phase_row_step >= cfg_dec) begin
                  phase_row_in = '0;
                  cell_row_in  = row_cell_step[CNT_W-1:0];
               end else begin
                  phase_row_in = phase_row_step[PHASE_W-1:0];
               end
            end
         end else begin
            src_col_in = src_col_step[CNT_W-1:0];
            if (phase_col_step >= cfg_dec) begin
               phase_col_in = '0;
               cell_col_in  = col_cell_step[CNT_W-1:0];
            end else begin
               phase_col_in = phase_col_step[PHASE_W-1:0];
            end
         end
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         cell_col_ff   <= '0;
         cell_row_ff   <= '0;
         phase_col_ff  <= '0;
         phase_row_ff  <= '0;
         word_count_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         src_col_ff    <= src_col_in;
         src_row_ff    <= src_row_in;
         cell_col_ff   <= cell_col_in;
         cell_row_ff   <= cell_row_in;
         phase_col_ff  <= phase_col_in;
         phase_row_ff  <= phase_row_in;
         word_count_ff <= word_count_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ctl_ff <= ctl_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_dx    = dx_ff;
   assign out_dy    = dy_ff;

endmodule

`default_nettype wire

/* design/abp_square.sv */
// Square stage: squares of the centre offsets, registered.
`default_nettype none

module abp_square
   import abp_pkg::*;
#(
   parameter int MAX_DIM = ABP_MAX_DIM
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        in_valid,
   output logic                                       in_ready,
   input  abp_ctl_type                                in_ctl,
   input  wire  signed [abp_dx_width(MAX_DIM)-1:0]    in_dx,
   input  wire  signed [abp_dx_width(MAX_DIM)-1:0]    in_dy,
   output logic                                       out_valid,
   input  wire                                        out_ready,
   output abp_ctl_type                                out_ctl,
   output logic [2*abp_dx_width(MAX_DIM)-1:0]         out_sq_x,
   output logic [2*abp_dx_width(MAX_DIM)-1:0]         out_sq_y
);

   localparam int SQ_W = 2 * abp_dx_width(MAX_DIM);

   logic              valid_ff, valid_in;
   abp_ctl_type       ctl_ff;
   logic [SQ_W-1:0]   sq_x_ff, sq_y_ff;
   logic signed [SQ_W-1:0] sq_x_in, sq_y_in;
   logic              fire;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;
   assign sq_x_in  = SQ_W'(in_dx) * SQ_W'(in_dx);
   assign sq_y_in  = SQ_W'(in_dy) * SQ_W'(in_dy);
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ctl_ff  <= in_ctl;
         sq_x_ff <= $unsigned(sq_x_in);
         sq_y_ff <= $unsigned(sq_y_in);
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_sq_x  = sq_x_ff;
   assign out_sq_y  = sq_y_ff;

endmodule

`default_nettype wire

/* design/abp_pack.sv */
// Pack stage: word accumulation, running maximum distance and result register.
`default_nettype none

module abp_pack
   import abp_pkg::*;
#(
   parameter int MAX_DIM = ABP_MAX_DIM
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   output logic                                  in_ready,
   input  abp_ctl_type                           in_ctl,
   input  wire  [2*abp_dx_width(MAX_DIM)-1:0]    in_sq_x,
   input  wire  [2*abp_dx_width(MAX_DIM)-1:0]    in_sq_y,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [WORD_BITS-1:0]                  rsp_mask_word,
   output logic [INDEX_W-1:0]                    rsp_word_index,
   output logic                                  rsp_mask_done,
   output logic [DIST_W-1:0]                     rsp_max_dist_sq
);

   localparam int SQ_W = 2 * abp_dx_width(MAX_DIM);

   logic [WORD_BITS-1:0] word_acc_ff, word_acc_in;
   logic [DIST_W-1:0]    best_dist_ff, best_dist_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] mask_word_ff;
   logic [INDEX_W-1:0]   word_index_ff;
   logic                 mask_done_ff;
   logic [DIST_W-1:0]    max_dist_ff;

   logic                 fire;
   logic [SQ_W:0]        dist_sum;
   logic [DIST_W-1:0]    dist_sat, best_new;
   logic [WORD_BITS-1:0] word_new, bit_mask;

   assign in_ready = !in_ctl.emit || !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      dist_sum = {1'b0, in_sq_x} + {1'b0, in_sq_y};
      dist_sat = (dist_sum > (SQ_W+1)'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_W-1:0];
      best_new = (in_ctl.opaque && (dist_sat > best_dist_ff)) ? dist_sat : best_dist_ff;
      bit_mask = WORD_BITS'(1) << in_ctl.bit_pos;
      word_new = in_ctl.opaque ? (word_acc_ff | bit_mask) : word_acc_ff;

      word_acc_in  = word_acc_ff;
      best_dist_in = best_dist_ff;
      if (fire) begin
         word_acc_in  = in_ctl.emit ? '0 : word_new;
         best_dist_in = best_new;
         // end of frame: drop everything gathered so far
         if (in_ctl.clear) begin
            word_acc_in  = '0;
            best_dist_in = '0;
         end
      end

      if (fire && in_ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_acc_ff  <= '0;
         best_dist_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_acc_ff  <= word_acc_in;
         best_dist_ff <= best_dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_ctl.emit) begin
         mask_word_ff  <= word_new;
         word_index_ff <= in_ctl.word_index;
         mask_done_ff  <= in_ctl.last;
         max_dist_ff   <= in_ctl.last ? best_new : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mask_word   = mask_word_ff;
   assign rsp_word_index  = word_index_ff;
   assign rsp_mask_done   = mask_done_ff;
   assign rsp_max_dist_sq = max_dist_ff;

endmodule

`default_nettype wire
